[rtl/core/vsf_pkg.sv]
// Shared types, codes and address helper for the voxel solid fill engine.
// Used by vsf_pipe, vsf_store and voxel_solid_fill_engine; depends on nothing.
package vsf_pkg;

  // Command codes carried in the op field.
  localparam logic [3:0] OP_PUT_VOXEL = 4'd0;
  localparam logic [3:0] OP_CUT_VOXEL = 4'd1;
  localparam logic [3:0] OP_PUT_BOX   = 4'd2;
  localparam logic [3:0] OP_CUT_BOX   = 4'd3;
  localparam logic [3:0] OP_PUT_SPH   = 4'd4;
  localparam logic [3:0] OP_CUT_SPH   = 4'd5;
  localparam logic [3:0] OP_PUT_ELL   = 4'd6;
  localparam logic [3:0] OP_CUT_ELL   = 4'd7;
  localparam logic [3:0] OP_READ      = 4'd8;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RANGE    = 2'd1;
  localparam logic [1:0] STATUS_REVERSED = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SIZE_X      = 3'd0;
  localparam logic [2:0] REG_SIZE_Y      = 3'd1;
  localparam logic [2:0] REG_SIZE_Z      = 3'd2;
  localparam logic [2:0] REG_PAINT_RED   = 3'd3;
  localparam logic [2:0] REG_PAINT_GREEN = 3'd4;
  localparam logic [2:0] REG_PAINT_BLUE  = 3'd5;
  localparam logic [2:0] REG_PAINT_ALPHA = 3'd6;

  // Write request into the voxel store.
  typedef struct packed {
    logic we_on;
    logic we_col;
    logic on_val;
  } wr_req_t;

  // Per-command mode of the voxel pipeline.
  typedef struct packed {
    logic put;
    logic test;
  } mode_t;

  // Linear store address of voxel (x, y, z), x outermost and z innermost.
  function automatic logic [24:0] cell_addr(input logic [7:0] x, input logic [7:0] y,
                                            input logic [7:0] z, input logic [24:0] my,
                                            input logic [24:0] mz);
    logic [24:0] t;
    t = {17'd0, x} * my + {17'd0, y};
    return t * mz + {17'd0, z};
  endfunction

endpackage

[rtl/core/vsf_store.sv]
// Voxel store: on-flag memory and RGBA colour memory, one write and one read port.
// Depends on vsf_pkg for the write request type.
module vsf_store #(
  parameter int CELLS = 32768,
  parameter int AW    = 15
) (
  input  logic             clk,
  input  vsf_pkg::wr_req_t wr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [31:0]      wr_color,
  input  logic [AW-1:0]    rd_addr,
  output logic             rd_on,
  output logic [31:0]      rd_color
);
  import vsf_pkg::*;

  logic        on_mem  [CELLS];
  logic [31:0] col_mem [CELLS];

  // The on flag and the colour are written separately so that a cut keeps the colour.
  always_ff @(posedge clk) begin
    if (wr.we_on) begin
      on_mem[wr_addr] <= wr.on_val;
    end
    if (wr.we_col) begin
      col_mem[wr_addr] <= wr_color;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_on    <= on_mem[rd_addr];
    rd_color <= col_mem[rd_addr];
  end

endmodule

[rtl/core/vsf_pipe.sv]
// Voxel pipeline: squares the offsets, weights them and tests the shape per voxel.
// Depends on vsf_pkg for the mode, the write request and the address helper.
module vsf_pipe #(
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32,
  parameter int AW    = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             issue_valid,
  input  logic [7:0]       i,
  input  logic [7:0]       j,
  input  logic [7:0]       k,
  input  logic [7:0]       x0,
  input  logic [7:0]       y0,
  input  logic [7:0]       z0,
  input  logic [31:0]      cx,
  input  logic [31:0]      cy,
  input  logic [31:0]      cz,
  input  logic [47:0]      lim,
  input  vsf_pkg::mode_t   mode,
  output vsf_pkg::wr_req_t wr,
  output logic [AW-1:0]    wr_addr,
  output logic             busy
);
  import vsf_pkg::*;

  logic [7:0]    dx, dy, dz;
  logic          v1, v2;
  logic [15:0]   sqx, sqy, sqz;
  logic [AW-1:0] a1, a2;
  logic [47:0]   tx, ty, tz;
  logic [49:0]   sum;
  logic          hit;

  // Absolute offsets from the centre.
  assign dx = (i > x0) ? i - x0 : x0 - i;
  assign dy = (j > y0) ? j - y0 : y0 - j;
  assign dz = (k > z0) ? k - z0 : z0 - k;

  // Valid bits of the two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue_valid;
      v2 <= v1;
    end
  end

  // Stage one: squared offsets and the store address.
  always_ff @(posedge clk) begin
    sqx <= 16'(dx) * 16'(dx);
    sqy <= 16'(dy) * 16'(dy);
    sqz <= 16'(dz) * 16'(dz);
    a1  <= AW'(cell_addr(i, j, k, 25'(MAX_Y), 25'(MAX_Z)));
  end

  // Stage two: each square times its weight.
  always_ff @(posedge clk) begin
    tx <= 48'(sqx) * 48'(cx);
    ty <= 48'(sqy) * 48'(cy);
    tz <= 48'(sqz) * 48'(cz);
    a2 <= a1;
  end

  // Shape test and write request.
  assign sum       = 50'(tx) + 50'(ty) + 50'(tz);
  assign hit       = !mode.test || (sum < {2'b00, lim});
  assign wr.we_on  = v2 && hit;
  assign wr.we_col = v2 && hit && mode.put;
  assign wr.on_val = mode.put;
  assign wr_addr   = a2;
  assign busy      = v1 || v2;

endmodule

[rtl/core/voxel_solid_fill_engine.sv]
// Voxel solid fill engine top level: command decode, scan sequencer, result register.
// Depends on vsf_pkg, vsf_pipe and vsf_store.
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid/s_tready    one command per beat
//  m_*       out        m_tvalid/m_tready    one result per beat
//  cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// After reset the store is cleared cell by cell over all MAX_X*MAX_Y*MAX_Z cells (32768 by default)
// while commands are held off; configuration writes are taken throughout.
// A sphere or ellipsoid passes S_SQ, S_CO and S_LIM, then scans all nx*ny*nz voxels; a box
// scans its volume and a single voxel that voxel, one voxel a cycle via the one store write
// port, then S_DRAIN; a read uses S_RD, S_RDW; a rejected or unused one goes to S_DONE.
// A finished result waits in the output register while the next command is taken.
module voxel_solid_fill_engine #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op, first_x, last_x, first_y, last_y, first_z, last_z, radius_x, radius_y, radius_z
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, voxel_on, voxel_red, voxel_green, voxel_blue, voxel_alpha
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import vsf_pkg::*;

  localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_CO    = 4'd3;
  localparam logic [3:0] S_LIM   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_RDW   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]    state;
  logic [AW-1:0] clr_addr;
  logic [5:0]    size_x, size_y, size_z;
  logic [7:0]    paint_red, paint_green, paint_blue, paint_alpha;
  logic [8:0]    nx, ny, nz;

  logic [3:0]    in_op;
  logic [7:0]    in_fx, in_lx, in_fy, in_ly, in_fz, in_lz, in_rx, in_ry, in_rz;
  logic          acc, first_in, last_in, reversed;

  logic [7:0]    x0, y0, z0, rx, ry, rz;
  logic [7:0]    lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic [7:0]    ci, cj, ck;
  logic [15:0]   ax, ay, az;
  logic [31:0]   cx, cy, cz;
  logic [47:0]   lim;
  mode_t         mode;
  logic          ellip;
  logic [1:0]    res_status;
  logic          res_on;
  logic [31:0]   res_col;

  wr_req_t       pipe_wr, st_wr;
  logic [AW-1:0] pipe_addr, st_addr, rd_addr;
  logic [31:0]   st_color, rd_color;
  logic          rd_on, busy;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= 6'd32;
      size_y      <= 6'd32;
      size_z      <= 6'd32;
      paint_red   <= 8'd0;
      paint_green <= 8'd0;
      paint_blue  <= 8'd0;
      paint_alpha <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIZE_X:      size_x      <= cfg_data[5:0];
        REG_SIZE_Y:      size_y      <= cfg_data[5:0];
        REG_SIZE_Z:      size_z      <= cfg_data[5:0];
        REG_PAINT_RED:   paint_red   <= cfg_data;
        REG_PAINT_GREEN: paint_green <= cfg_data;
        REG_PAINT_BLUE:  paint_blue  <= cfg_data;
        REG_PAINT_ALPHA: paint_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  // Extents in use, saturated at the store dimensions.
  assign nx = ({3'b000, size_x} > 9'(MAX_X)) ? 9'(MAX_X) : {3'b000, size_x};
  assign ny = ({3'b000, size_y} > 9'(MAX_Y)) ? 9'(MAX_Y) : {3'b000, size_y};
  assign nz = ({3'b000, size_z} > 9'(MAX_Z)) ? 9'(MAX_Z) : {3'b000, size_z};

  // Command fields and checks.
  assign in_op = s_tdata[3:0];
  assign in_fx = s_tdata[11:4];
  assign in_lx = s_tdata[19:12];
  assign in_fy = s_tdata[27:20];
  assign in_ly = s_tdata[35:28];
  assign in_fz = s_tdata[43:36];
  assign in_lz = s_tdata[51:44];
  assign in_rx = s_tdata[59:52];
  assign in_ry = s_tdata[67:60];
  assign in_rz = s_tdata[75:68];

  assign first_in = ({1'b0, in_fx} < nx) && ({1'b0, in_fy} < ny) && ({1'b0, in_fz} < nz);
  assign last_in  = ({1'b0, in_lx} < nx) && ({1'b0, in_ly} < ny) && ({1'b0, in_lz} < nz);
  assign reversed = (in_fx > in_lx) || (in_fy > in_ly) || (in_fz > in_lz);

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;

  // Sequencer: clear pass, setup, scan, read and result hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The hand-off state reloads the output register itself.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            x0         <= in_fx;
            y0         <= in_fy;
            z0         <= in_fz;
            rx         <= in_rx;
            ry         <= in_ry;
            rz         <= in_rz;
            mode.put   <= ~in_op[0];
            ellip      <= (in_op[2:1] == 2'b11);
            res_status <= STATUS_OK;
            res_on     <= 1'b0;
            res_col    <= 32'd0;
            if (in_op > OP_READ) begin
              state <= S_DONE;
            end else if (!first_in) begin
              res_status <= STATUS_RANGE;
              state      <= S_DONE;
            end else if (in_op inside {OP_PUT_VOXEL, OP_CUT_VOXEL}) begin
              mode.test <= 1'b0;
              lo_x <= in_fx; lo_y <= in_fy; lo_z <= in_fz;
              hi_x <= in_fx; hi_y <= in_fy; hi_z <= in_fz;
              ci   <= in_fx; cj   <= in_fy; ck   <= in_fz;
              state <= S_SCAN;
            end else if (in_op inside {OP_PUT_BOX, OP_CUT_BOX}) begin
              if (!last_in) begin
                res_status <= STATUS_RANGE;
                state      <= S_DONE;
              end else if (reversed) begin
                res_status <= STATUS_REVERSED;
                state      <= S_DONE;
              end else begin
                mode.test <= 1'b0;
                lo_x <= in_fx; lo_y <= in_fy; lo_z <= in_fz;
                hi_x <= in_lx; hi_y <= in_ly; hi_z <= in_lz;
                ci   <= in_fx; cj   <= in_fy; ck   <= in_fz;
                state <= S_SCAN;
              end
            end else if (in_op == OP_READ) begin
              state <= S_RD;
            end else begin
              mode.test <= 1'b1;
              lo_x <= 8'd0; lo_y <= 8'd0; lo_z <= 8'd0;
              hi_x <= 8'(nx - 9'd1);
              hi_y <= 8'(ny - 9'd1);
              hi_z <= 8'(nz - 9'd1);
              ci   <= 8'd0; cj   <= 8'd0; ck   <= 8'd0;
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          ax    <= 16'(rx) * 16'(rx);
          ay    <= 16'(ry) * 16'(ry);
          az    <= 16'(rz) * 16'(rz);
          state <= S_CO;
        end
        S_CO: begin
          if (ellip) begin
            cx <= 32'(ay) * 32'(az);
            cy <= 32'(ax) * 32'(az);
            cz <= 32'(ax) * 32'(ay);
          end else begin
            cx <= 32'd1;
            cy <= 32'd1;
            cz <= 32'd1;
          end
          state <= S_LIM;
        end
        S_LIM: begin
          lim   <= ellip ? 48'(ax) * 48'(cx) : 48'(ax);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (ck == hi_z) begin
            ck <= lo_z;
            if (cj == hi_y) begin
              cj <= lo_y;
              if (ci == hi_x) begin
                state <= S_DRAIN;
              end else begin
                ci <= ci + 8'd1;
              end
            end else begin
              cj <= cj + 8'd1;
            end
          end else begin
            ck <= ck + 8'd1;
          end
        end
        S_DRAIN: begin
          if (!busy) begin
            state <= S_DONE;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          res_on  <= rd_on;
          res_col <= rd_color;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {5'd0, res_col[7:0], res_col[15:8], res_col[23:16],
                         res_col[31:24], res_on, res_status};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Per-voxel test pipeline.
  vsf_pipe #(
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z),
    .AW    (AW)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (state == S_SCAN),
    .i           (ci),
    .j           (cj),
    .k           (ck),
    .x0          (x0),
    .y0          (y0),
    .z0          (z0),
    .cx          (cx),
    .cy          (cy),
    .cz          (cz),
    .lim         (lim),
    .mode        (mode),
    .wr          (pipe_wr),
    .wr_addr     (pipe_addr),
    .busy        (busy)
  );

  // Store write selection: clearing pass or pipeline.
  always_comb begin
    if (state == S_CLEAR) begin
      st_wr.we_on  = 1'b1;
      st_wr.we_col = 1'b1;
      st_wr.on_val = 1'b0;
      st_addr      = clr_addr;
      st_color     = 32'd0;
    end else begin
      st_wr    = pipe_wr;
      st_addr  = pipe_addr;
      st_color = {paint_red, paint_green, paint_blue, paint_alpha};
    end
  end

  assign rd_addr = AW'(cell_addr(x0, y0, z0, 25'(MAX_Y), 25'(MAX_Z)));

  vsf_store #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr       (st_wr),
    .wr_addr  (st_addr),
    .wr_color (st_color),
    .rd_addr  (rd_addr),
    .rd_on    (rd_on),
    .rd_color (rd_color)
  );

`ifndef SYNTHESIS
  // No command is taken during the clearing pass.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("command accepted during clearing pass");

  // The pipeline is empty whenever a command may be taken.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy)
    else $error("pipeline busy while idle");

  // A result is only raised from the hand-off state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside hand-off");

  // The pipeline never writes outside a scan or its drain.
  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    pipe_wr.we_on |-> (state == S_SCAN || state == S_DRAIN))
    else $error("store write outside scan");
`endif

endmodule
